/* design/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg: shared constants for the 3x3 matrix inverse core
// Element count, quotient width, result scaling and saturation limits.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int NUM_ELEM   = 9;
  localparam int NUM_PROD   = 18;
  localparam int FRAC_SHIFT = 24;   // Q8.8 in, Q16.16 out: cofactor * 2^24 / det
  localparam int QBITS      = 33;   // quotient bits kept before saturation
  localparam int OUT_W      = 32;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic [OUT_W-1:0] res_t;

endpackage

/* design/matrix3_inverse_core.sv */
// ----------------------------------------------------------------------------
// matrix3_inverse_core: pipelined 3x3 matrix inverse by the adjugate
// Signed Q8.8 elements in, signed Q16.16 inverse out, saturated to 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one request: all nine elements
//   in_aRC of a matrix. Output channel out_valid/out_ready returns the nine
//   inverse elements out_bRC and out_singular (set, with all elements zero,
//   when the determinant is exactly zero).
//   The pipeline has four stages of cofactor and determinant arithmetic, one
//   set-up stage for the dividers, 33 restoring division stages (one quotient
//   bit each, nine lanes side by side) and the output register. It takes one
//   request per cycle while the output register is not held by out_ready.
//   The whole pipeline advances together: when the output register holds a
//   result that is not taken, every stage holds and in_ready drops; nothing
//   is lost or repeated. Reset clears all valid bits; data registers are
//   left as they are.
// ----------------------------------------------------------------------------
module matrix3_inverse_core #(
  parameter int IN_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [IN_WIDTH-1:0] in_a00,
  input  logic signed [IN_WIDTH-1:0] in_a01,
  input  logic signed [IN_WIDTH-1:0] in_a02,
  input  logic signed [IN_WIDTH-1:0] in_a10,
  input  logic signed [IN_WIDTH-1:0] in_a11,
  input  logic signed [IN_WIDTH-1:0] in_a12,
  input  logic signed [IN_WIDTH-1:0] in_a20,
  input  logic signed [IN_WIDTH-1:0] in_a21,
  input  logic signed [IN_WIDTH-1:0] in_a22,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mi3_pkg::res_t             out_b00,
  output mi3_pkg::res_t             out_b01,
  output mi3_pkg::res_t             out_b02,
  output mi3_pkg::res_t             out_b10,
  output mi3_pkg::res_t             out_b11,
  output mi3_pkg::res_t             out_b12,
  output mi3_pkg::res_t             out_b20,
  output mi3_pkg::res_t             out_b21,
  output mi3_pkg::res_t             out_b22,
  output logic                      out_singular
);
  import mi3_pkg::*;

  localparam int PW   = 2 * IN_WIDTH;        // minor product
  localparam int CW   = 2 * IN_WIDTH + 1;    // cofactor
  localparam int DPW  = 3 * IN_WIDTH + 1;    // determinant term
  localparam int DETW = 3 * IN_WIDTH + 3;    // determinant
  localparam int NW   = CW + FRAC_SHIFT;     // scaled cofactor magnitude
  localparam int RW   = DETW + 1;            // partial remainder

  // pipeline advances as one
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: minor products ----------------
  logic signed [IN_WIDTH-1:0] a [NUM_ELEM];
  assign a = '{in_a00, in_a01, in_a02, in_a10, in_a11, in_a12, in_a20, in_a21, in_a22};

  logic signed [PW-1:0]       p_nxt [NUM_PROD];
  logic signed [PW-1:0]       p_r   [NUM_PROD];
  logic signed [IN_WIDTH-1:0] a1_r  [3];
  logic                       v1_r;

  // form both products of every cofactor pair
  always_comb begin
    p_nxt[0]  = a[4] * a[8];  p_nxt[1]  = a[5] * a[7];
    p_nxt[2]  = a[2] * a[7];  p_nxt[3]  = a[1] * a[8];
    p_nxt[4]  = a[1] * a[5];  p_nxt[5]  = a[2] * a[4];
    p_nxt[6]  = a[5] * a[6];  p_nxt[7]  = a[3] * a[8];
    p_nxt[8]  = a[0] * a[8];  p_nxt[9]  = a[2] * a[6];
    p_nxt[10] = a[2] * a[3];  p_nxt[11] = a[0] * a[5];
    p_nxt[12] = a[3] * a[7];  p_nxt[13] = a[4] * a[6];
    p_nxt[14] = a[1] * a[6];  p_nxt[15] = a[0] * a[7];
    p_nxt[16] = a[0] * a[4];  p_nxt[17] = a[1] * a[3];
  end

  // ---------------- stage 2: cofactors ----------------
  logic signed [CW-1:0]       c2_nxt [NUM_ELEM];
  logic signed [CW-1:0]       c2_r   [NUM_ELEM];
  logic signed [IN_WIDTH-1:0] a2_r   [3];
  logic                       v2_r;

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      c2_nxt[k] = CW'(p_r[2*k]) - CW'(p_r[2*k+1]);
    end
  end

  // ---------------- stage 3: determinant terms ----------------
  logic signed [DPW-1:0] dp_nxt [3];
  logic signed [DPW-1:0] dp_r   [3];
  logic signed [CW-1:0]  c3_r   [NUM_ELEM];
  logic                  v3_r;

  always_comb begin
    logic signed [DPW-1:0] ax;
    logic signed [DPW-1:0] cx;
    for (int j = 0; j < 3; j++) begin
      ax        = DPW'(a2_r[j]);
      cx        = DPW'(c2_r[3*j]);
      dp_nxt[j] = ax * cx;
    end
  end

  // ---------------- stage 4: determinant ----------------
  logic signed [DETW-1:0] det_nxt;
  logic signed [DETW-1:0] det_r;
  logic signed [CW-1:0]   c4_r [NUM_ELEM];
  logic                   v4_r;

  assign det_nxt = DETW'(dp_r[0]) + DETW'(dp_r[1]) + DETW'(dp_r[2]);

  // ---------------- division stages ----------------
  // stage 0 is divider set-up, stage s (1..QBITS) resolves one quotient bit
  logic [DETW-1:0]  dm_r   [QBITS+1];
  logic             sg_r   [QBITS+1];
  logic             vd_r   [QBITS+1];
  logic [RW-1:0]    rm_r   [QBITS+1][NUM_ELEM];
  logic [QBITS-1:0] nl_r   [QBITS+1][NUM_ELEM];
  logic [QBITS-1:0] q_r    [QBITS+1][NUM_ELEM];
  logic             ng_r   [QBITS+1][NUM_ELEM];
  logic             ov_r   [QBITS+1][NUM_ELEM];

  logic [DETW-1:0]  dm_nxt;
  logic [RW-1:0]    rm_nxt [QBITS+1][NUM_ELEM];
  logic [QBITS-1:0] nl_nxt [QBITS+1][NUM_ELEM];
  logic [QBITS-1:0] q_nxt  [QBITS+1][NUM_ELEM];
  logic             ng_nxt [NUM_ELEM];
  logic             ov_nxt [NUM_ELEM];

  // set up magnitudes, signs, overflow test and first remainder,
  // then one restoring step per stage and lane
  always_comb begin
    logic [CW-1:0] cm;
    logic [NW-1:0] nm;
    logic [RW-1:0] hi;
    logic [RW-1:0] t;
    dm_nxt = det_r[DETW-1] ? DETW'(-det_r) : DETW'(det_r);
    for (int k = 0; k < NUM_ELEM; k++) begin
      cm              = c4_r[k][CW-1] ? CW'(-c4_r[k]) : CW'(c4_r[k]);
      nm              = {cm, {FRAC_SHIFT{1'b0}}};
      hi              = RW'(nm[NW-1:QBITS]);
      ng_nxt[k]       = c4_r[k][CW-1] ^ det_r[DETW-1];
      ov_nxt[k]       = hi >= {1'b0, dm_nxt};
      rm_nxt[0][k]    = hi;
      nl_nxt[0][k]    = nm[QBITS-1:0];
      q_nxt[0][k]     = '0;
    end
    for (int s = 1; s <= QBITS; s++) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        t = {rm_r[s-1][k][RW-2:0], nl_r[s-1][k][QBITS-1]};
        nl_nxt[s][k] = {nl_r[s-1][k][QBITS-2:0], 1'b0};
        if (t >= {1'b0, dm_r[s-1]}) begin
          rm_nxt[s][k] = t - {1'b0, dm_r[s-1]};
          q_nxt[s][k]  = {q_r[s-1][k][QBITS-2:0], 1'b1};
        end else begin
          rm_nxt[s][k] = t;
          q_nxt[s][k]  = {q_r[s-1][k][QBITS-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- output: sign and saturate, zero if singular ----------------
  res_t b_nxt [NUM_ELEM];
  res_t b_r   [NUM_ELEM];
  logic sing_r;

  always_comb begin
    logic [QBITS-1:0] q;
    for (int k = 0; k < NUM_ELEM; k++) begin
      q = q_r[QBITS][k];
      if (sg_r[QBITS]) begin
        b_nxt[k] = '0;
      end else if (ng_r[QBITS][k]) begin
        if (ov_r[QBITS][k] || q > QBITS'(SAT_NEG)) b_nxt[k] = SAT_NEG;
        else b_nxt[k] = OUT_W'(-q);
      end else begin
        if (ov_r[QBITS][k] || q > QBITS'(SAT_POS)) b_nxt[k] = SAT_POS;
        else b_nxt[k] = OUT_W'(q);
      end
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= p_nxt;
      a1_r <= '{a[0], a[1], a[2]};
      c2_r <= c2_nxt;
      a2_r <= a1_r;
      dp_r <= dp_nxt;
      c3_r <= c2_r;
      det_r <= det_nxt;
      c4_r  <= c3_r;
      dm_r[0] <= dm_nxt;
      sg_r[0] <= (det_r == '0);
      for (int k = 0; k < NUM_ELEM; k++) begin
        ng_r[0][k] <= ng_nxt[k];
        ov_r[0][k] <= ov_nxt[k];
      end
      for (int s = 0; s <= QBITS; s++) begin
        rm_r[s] <= rm_nxt[s];
        nl_r[s] <= nl_nxt[s];
        q_r[s]  <= q_nxt[s];
      end
      for (int s = 1; s <= QBITS; s++) begin
        dm_r[s] <= dm_r[s-1];
        sg_r[s] <= sg_r[s-1];
        ng_r[s] <= ng_r[s-1];
        ov_r[s] <= ov_r[s-1];
      end
      b_r    <= b_nxt;
      sing_r <= sg_r[QBITS];
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int s = 0; s <= QBITS; s++) begin
        vd_r[s] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      vd_r[0] <= v4_r;
      for (int s = 1; s <= QBITS; s++) begin
        vd_r[s] <= vd_r[s-1];
      end
      out_valid_r <= vd_r[QBITS];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_singular = sing_r;
  assign out_b00 = b_r[0];
  assign out_b01 = b_r[1];
  assign out_b02 = b_r[2];
  assign out_b10 = b_r[3];
  assign out_b11 = b_r[4];
  assign out_b12 = b_r[5];
  assign out_b20 = b_r[6];
  assign out_b21 = b_r[7];
  assign out_b22 = b_r[8];

endmodule
